FILE: rtl/vcbh_pkg.sv
package vcbh_pkg;

    localparam int W = 16;
    localparam int STEPS = 16;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);
    localparam logic [31:0] SQRT_BIT0 = 32'h4000_0000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD  = 2'd3;

    localparam logic [W-1:0] LIMIT_RST = 16'd7040;
    localparam logic [W-1:0] BRAKE_RST = 16'd2400;
    localparam logic [W-1:0] STOP_RST  = 16'd640;
    localparam logic [W-1:0] HOLD_RST  = 16'd200;

    typedef struct packed {
        logic signed [W-1:0] speed_x;
        logic signed [W-1:0] speed_y;
        logic signed [W-1:0] speed_rot;
        logic                module_reset;
    } vcbh_in_t;

    typedef struct packed {
        logic signed [W-1:0] out_x;
        logic signed [W-1:0] out_y;
        logic signed [W-1:0] out_rot;
        logic                error;
    } vcbh_out_t;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic        [W-1:0] limit;
    } vcbh_job_t;

    typedef struct packed {
        logic        [W-1:0] mag;
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
    } vcbh_res_t;

endpackage

FILE: rtl/velocity_clamp_brake_hold_top.sv
// Sequencing: a module-reset command bypasses the engine and goes straight to the output
// state; other commands run a 16-step square root and, when the magnitude exceeds the
// limit, two 16-step divides that scale x and y, all on the shared multiply/subtract unit.
// s_ready is high only in the idle state, so a new transaction is accepted only after
// the previous result has been loaded into the output register.
// Reset: synchronous active-low aresetn restores register defaults and clears
// last magnitude, hold count and output valid.
module velocity_clamp_brake_hold_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  vcbh_pkg::vcbh_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output vcbh_pkg::vcbh_out_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vcbh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vcbh_pkg::W-1:0]            cfg_data
);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_RUN  = 2'd1;
    localparam logic [1:0] T_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg;

    logic [15:0] limit_reg, brake_reg, stop_reg, hold_ticks_reg;
    logic [15:0] last_mag_reg, hold_reg, hold_next, hold_eff;

    vcbh_pkg::vcbh_in_t  in_reg;
    vcbh_pkg::vcbh_out_t out_reg, out_next;
    vcbh_pkg::vcbh_job_t eng_job;
    vcbh_pkg::vcbh_res_t eng_res;

    logic accept, start, eng_done, out_free, load, brake;

    vcbh_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .job     (eng_job),
        .done    (eng_done),
        .res     (eng_res)
    );

    always_comb begin
        s_ready   = (state_reg == T_IDLE);
        cfg_ready = 1'b1;
        accept    = s_valid && s_ready;
        start     = accept && !s_data.module_reset;
        out_free  = !m_valid_reg || m_ready;
        load      = (state_reg == T_OUT) && out_free;

        eng_job.x     = s_data.speed_x;
        eng_job.y     = s_data.speed_y;
        eng_job.limit = limit_reg;

        brake     = (last_mag_reg > brake_reg) && (eng_res.mag < stop_reg);
        hold_eff  = brake ? hold_ticks_reg : hold_reg;
        hold_next = (hold_eff != 16'd0) ? hold_eff - 16'd1 : hold_eff;

        if (in_reg.module_reset) begin
            out_next       = '0;
            out_next.error = 1'b1;
        end else begin
            out_next.out_x   = eng_res.x;
            out_next.out_y   = eng_res.y;
            out_next.out_rot = (hold_eff != 16'd0) ? 16'sd0 : in_reg.speed_rot;
            out_next.error   = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE: begin
                if (accept) state_next = s_data.module_reset ? T_OUT : T_RUN;
            end
            T_RUN:  if (eng_done) state_next = T_OUT;
            T_OUT:  if (out_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= T_IDLE;
            m_valid_reg    <= 1'b0;
            limit_reg      <= vcbh_pkg::LIMIT_RST;
            brake_reg      <= vcbh_pkg::BRAKE_RST;
            stop_reg       <= vcbh_pkg::STOP_RST;
            hold_ticks_reg <= vcbh_pkg::HOLD_RST;
            last_mag_reg   <= '0;
            hold_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    vcbh_pkg::REG_LIMIT: limit_reg      <= cfg_data;
                    vcbh_pkg::REG_BRAKE: brake_reg      <= cfg_data;
                    vcbh_pkg::REG_STOP:  stop_reg       <= cfg_data;
                    vcbh_pkg::REG_HOLD:  hold_ticks_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (load && !in_reg.module_reset) begin
                last_mag_reg <= eng_res.mag;
                hold_reg     <= hold_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_data;
        end
        if (load) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_done |-> state_reg == T_RUN)
        else $error("engine finished outside run state");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == T_OUT)
        else $error("result raised without output state");

    a_modreset_bypass: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.module_reset) |=> state_reg == T_OUT)
        else $error("module-reset transaction did not bypass engine");
`endif

endmodule

FILE: rtl/vcbh_unit.sv
module vcbh_unit (
    input  logic [vcbh_pkg::W-1:0]   mul_a,
    input  logic [vcbh_pkg::W-1:0]   mul_b,
    output logic [2*vcbh_pkg::W-1:0] prod,
    input  logic [2*vcbh_pkg::W:0]   sub_a,
    input  logic [2*vcbh_pkg::W:0]   sub_b,
    output logic [2*vcbh_pkg::W:0]   diff
);

    assign prod = mul_a * mul_b;
    assign diff = sub_a - sub_b;

endmodule

FILE: rtl/vcbh_engine.sv
module vcbh_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  vcbh_pkg::vcbh_job_t job,
    output logic                done,
    output vcbh_pkg::vcbh_res_t res
);

    localparam logic [3:0] E_IDLE = 4'd0;
    localparam logic [3:0] E_SQX  = 4'd1;
    localparam logic [3:0] E_SQY  = 4'd2;
    localparam logic [3:0] E_SQRT = 4'd3;
    localparam logic [3:0] E_CHK  = 4'd4;
    localparam logic [3:0] E_MULX = 4'd5;
    localparam logic [3:0] E_DIVX = 4'd6;
    localparam logic [3:0] E_MULY = 4'd7;
    localparam logic [3:0] E_DIVY = 4'd8;
    localparam logic [3:0] E_DONE = 4'd9;

    logic [3:0] state_reg, state_next;

    logic [15:0]                 ax_reg, ay_reg, lim_reg, mag_reg;
    logic                        negx_reg, negy_reg;
    logic [31:0]                 acc_reg, root_reg, bit_reg;
    logic [15:0]                 rem_reg, dq_reg, qx_reg, qy_reg;
    logic [vcbh_pkg::CNT_W-1:0]  cnt_reg;

    logic [15:0] mul_a, mul_b;
    logic [31:0] prod, trial;
    logic [32:0] sub_a, sub_b, diff;
    logic [16:0] div_t;
    logic        ge;
    logic [15:0] dq_step, rem_step;

    vcbh_unit u_unit (
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod),
        .sub_a (sub_a),
        .sub_b (sub_b),
        .diff  (diff)
    );

    always_comb begin
        trial = root_reg + bit_reg;
        div_t = {rem_reg, dq_reg[15]};
        mul_a = ax_reg;
        mul_b = ax_reg;
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            E_SQY: begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            E_SQRT: begin
                sub_a = {1'b0, acc_reg};
                sub_b = {1'b0, trial};
            end
            E_CHK: begin
                sub_a = {17'd0, lim_reg};
                sub_b = {17'd0, root_reg[15:0]};
            end
            E_MULX: begin
                mul_b = lim_reg;
            end
            E_MULY: begin
                mul_a = ay_reg;
                mul_b = lim_reg;
            end
            E_DIVX, E_DIVY: begin
                sub_a = {16'd0, div_t};
                sub_b = {17'd0, mag_reg};
            end
            default: ;
        endcase
        ge       = ~diff[32];
        dq_step  = {dq_reg[14:0], ge};
        rem_step = ge ? diff[15:0] : div_t[15:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            E_IDLE: if (start) state_next = E_SQX;
            E_SQX:  state_next = E_SQY;
            E_SQY:  state_next = E_SQRT;
            E_SQRT: if (cnt_reg == vcbh_pkg::CNT_LAST) state_next = E_CHK;
            E_CHK:  state_next = diff[32] ? E_MULX : E_DONE;
            E_MULX: state_next = E_DIVX;
            E_DIVX: if (cnt_reg == vcbh_pkg::CNT_LAST) state_next = E_MULY;
            E_MULY: state_next = E_DIVY;
            E_DIVY: if (cnt_reg == vcbh_pkg::CNT_LAST) state_next = E_DONE;
            E_DONE: state_next = E_IDLE;
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            E_IDLE: begin
                if (start) begin
                    ax_reg   <= job.x[15] ? 16'(-job.x) : 16'(job.x);
                    ay_reg   <= job.y[15] ? 16'(-job.y) : 16'(job.y);
                    negx_reg <= job.x[15];
                    negy_reg <= job.y[15];
                    lim_reg  <= job.limit;
                end
            end
            E_SQX: begin
                acc_reg <= prod;
            end
            E_SQY: begin
                acc_reg  <= acc_reg + prod;
                root_reg <= '0;
                bit_reg  <= vcbh_pkg::SQRT_BIT0;
                cnt_reg  <= '0;
            end
            E_SQRT: begin
                if (ge) begin
                    acc_reg  <= diff[31:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
            end
            E_CHK: begin
                mag_reg <= root_reg[15:0];
                qx_reg  <= ax_reg;
                qy_reg  <= ay_reg;
            end
            E_MULX, E_MULY: begin
                rem_reg <= prod[31:16];
                dq_reg  <= prod[15:0];
                cnt_reg <= '0;
            end
            E_DIVX: begin
                rem_reg <= rem_step;
                dq_reg  <= dq_step;
                qx_reg  <= dq_step;
                cnt_reg <= cnt_reg + 1'b1;
            end
            E_DIVY: begin
                rem_reg <= rem_step;
                dq_reg  <= dq_step;
                qy_reg  <= dq_step;
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign done    = (state_reg == E_DONE);
    assign res.mag = mag_reg;
    assign res.x   = negx_reg ? $signed(16'(-qx_reg)) : $signed(qx_reg);
    assign res.y   = negy_reg ? $signed(16'(-qy_reg)) : $signed(qy_reg);

endmodule

FILE: bench/velocity_cmd_checker.sv
module velocity_cmd_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  vcbh_pkg::vcbh_in_t             s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  vcbh_pkg::vcbh_out_t            m_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [vcbh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vcbh_pkg::W-1:0]         cfg_data,
    output int                             fail_count,
    output int                             outstanding
);
    import vcbh_pkg::*;

    logic [W-1:0] lim_q;
    logic [W-1:0] brake_q;
    logic [W-1:0] stop_q;
    logic [W-1:0] hold_q;
    logic [W-1:0] prev_mag;
    logic [W-1:0] hold_left;
    vcbh_out_t    expected_cmds[$];
    int           errs = 0;

    assign fail_count = errs;

    initial outstanding = 0;

    function automatic logic [W-1:0] floor_sqrt(input logic [31:0] n);
        logic [31:0] rem;
        logic [31:0] root;
        logic [31:0] b;
        rem  = n;
        root = '0;
        b    = 32'h4000_0000;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root[W-1:0];
    endfunction

    // |v| * lim / mag, truncated toward zero, sign restored
    function automatic logic [W-1:0] shrink_axis(input logic [W-1:0] v,
                                                 input logic [W-1:0] lim,
                                                 input logic [W-1:0] mag);
        logic [W:0]     ext;
        logic [W:0]     av;
        logic [2*W:0]   prod;
        logic [2*W:0]   q;
        ext  = {v[W-1], v};
        av   = v[W-1] ? (17'd0 - ext) : ext;
        prod = av * lim;
        q    = prod / mag;
        return v[W-1] ? (16'd0 - q[W-1:0]) : q[W-1:0];
    endfunction

    function automatic vcbh_out_t clamp_and_hold(input vcbh_in_t c);
        vcbh_out_t          r;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        logic [31:0]        sum;
        logic [W-1:0]       mag;
        r = '0;
        if (c.module_reset) begin
            r.error = 1'b1;
            return r;
        end
        xs  = c.speed_x;
        ys  = c.speed_y;
        sum = xs * xs + ys * ys;
        mag = floor_sqrt(sum);
        r.out_x   = c.speed_x;
        r.out_y   = c.speed_y;
        r.out_rot = c.speed_rot;
        if (mag > lim_q) begin
            r.out_x = shrink_axis(c.speed_x, lim_q, mag);
            r.out_y = shrink_axis(c.speed_y, lim_q, mag);
        end
        if (prev_mag > brake_q && mag < stop_q) hold_left = hold_q;
        if (hold_left != 0) begin
            r.out_rot = '0;
            hold_left = hold_left - 16'd1;
        end
        prev_mag = mag;
        return r;
    endfunction

    always @(posedge aclk) begin : track
        vcbh_out_t want;
        if (!aresetn) begin
            lim_q     = LIMIT_RST;
            brake_q   = BRAKE_RST;
            stop_q    = STOP_RST;
            hold_q    = HOLD_RST;
            prev_mag  = '0;
            hold_left = '0;
            expected_cmds.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LIMIT: lim_q   = cfg_data;
                    REG_BRAKE: brake_q = cfg_data;
                    REG_STOP:  stop_q  = cfg_data;
                    REG_HOLD:  hold_q  = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) expected_cmds.push_back(clamp_and_hold(s_data));
            if (m_valid && m_ready) begin
                if (expected_cmds.size() == 0) begin
                    if (errs < 10)
                        $display("unexpected transaction: x=%0d y=%0d rot=%0d err=%0b",
                                 m_data.out_x, m_data.out_y, m_data.out_rot,
                                 m_data.error);
                    errs++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (m_data.out_x !== want.out_x || m_data.out_y !== want.out_y ||
                        m_data.out_rot !== want.out_rot || m_data.error !== want.error) begin
                        if (errs < 10)
                            $display({"mismatch: exp x=%0d y=%0d rot=%0d err=%0b",
                                      " got x=%0d y=%0d rot=%0d err=%0b"},
                                     want.out_x, want.out_y, want.out_rot, want.error,
                                     m_data.out_x, m_data.out_y, m_data.out_rot,
                                     m_data.error);
                        errs++;
                    end
                end
            end
        end
        outstanding <= expected_cmds.size();
    end

endmodule

FILE: bench/tb_velocity_clamp_brake_hold_top.sv
module tb_velocity_clamp_brake_hold_top;
    import vcbh_pkg::*;

    localparam int PHASES     = 8;
    localparam int PER_PHASE  = 160;
    localparam int LONG_HOLD  = 400;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    vcbh_in_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    vcbh_out_t            m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [W-1:0]         cfg_data;
    int                   fail_count;
    int                   outstanding;
    bit                   long_stall_req = 1'b0;
    vcbh_in_t             directed_cmds[$];

    velocity_clamp_brake_hold_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    velocity_cmd_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic vcbh_in_t mk_cmd(input int x, input int y, input int rot,
                                        input bit mrst);
        vcbh_in_t c;
        c.speed_x      = 16'(x);
        c.speed_y      = 16'(y);
        c.speed_rot    = 16'(rot);
        c.module_reset = mrst;
        return c;
    endfunction

    // mix of fast, slow and near-threshold commands so brakes happen often
    function automatic vcbh_in_t next_cmd();
        vcbh_in_t c;
        int       sel;
        sel            = $urandom_range(0, 99);
        c.speed_x      = 16'($urandom);
        c.speed_y      = 16'($urandom);
        c.speed_rot    = 16'($urandom);
        c.module_reset = 1'b0;
        if (sel < 5) begin
            c.module_reset = 1'b1;
        end else if (sel < 35) begin
        end else if (sel < 65) begin
            c.speed_x = 16'($urandom_range(0, 80)) - 16'd40;
            c.speed_y = 16'($urandom_range(0, 80)) - 16'd40;
        end else if (sel < 85) begin
            c.speed_x = 16'($urandom_range(0, 16000)) - 16'd8000;
            c.speed_y = 16'($urandom_range(0, 16000)) - 16'd8000;
        end else begin
            c.speed_x = 16'($urandom_range(0, 1000)) - 16'd500;
            c.speed_y = 16'($urandom);
        end
        if ($urandom_range(0, 9) == 0) c.speed_rot = '0;
        return c;
    endfunction

    task automatic send_cmd(input vcbh_in_t c);
        s_data  <= c;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic play_directed();
        foreach (directed_cmds[i]) send_cmd(directed_cmds[i]);
        s_valid <= 1'b0;
        directed_cmds.delete();
    endtask

    task automatic drain();
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_cfg(input logic [W-1:0] lim, input logic [W-1:0] brk,
                             input logic [W-1:0] stp, input logic [W-1:0] hld);
        write_reg(REG_LIMIT, lim);
        write_reg(REG_BRAKE, brk);
        write_reg(REG_STOP, stp);
        write_reg(REG_HOLD, hld);
        cfg_valid <= 1'b0;
    endtask

    initial begin : sink
        int cyc;
        cyc     = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                case ((cyc / 151) % 3)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 1) == 1);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int sent;
        int burst;
        int gap;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default registers: extremes, limit edge, brake, hold, reload
        directed_cmds.push_back(mk_cmd(0, 0, 100, 0));
        directed_cmds.push_back(mk_cmd(32767, 32767, -32768, 0));
        directed_cmds.push_back(mk_cmd(-32768, -32768, 32767, 0));
        directed_cmds.push_back(mk_cmd(-32768, 0, 1, 0));
        directed_cmds.push_back(mk_cmd(0, 32767, -1, 0));
        directed_cmds.push_back(mk_cmd(7040, 0, 11, 0));
        directed_cmds.push_back(mk_cmd(7041, 0, 12, 0));
        directed_cmds.push_back(mk_cmd(-4979, -4979, 13, 0));
        directed_cmds.push_back(mk_cmd(1234, -5, 77, 1));
        directed_cmds.push_back(mk_cmd(3000, 0, 500, 0));
        directed_cmds.push_back(mk_cmd(10, 10, 700, 0));
        directed_cmds.push_back(mk_cmd(100, 0, -9, 0));
        directed_cmds.push_back(mk_cmd(-1, -1, -1, 1));
        directed_cmds.push_back(mk_cmd(5000, 0, 1, 0));
        directed_cmds.push_back(mk_cmd(0, 0, 3, 0));
        directed_cmds.push_back(mk_cmd(-2, 3, 4, 0));
        play_directed();
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_cfg(LIMIT_RST, BRAKE_RST, STOP_RST, HOLD_RST);
                1: apply_cfg(16'd0, 16'd0, 16'd46341, 16'd0);
                2: apply_cfg(16'd46341, 16'd0, 16'd46341, 16'hFFFF);
                3: apply_cfg(LIMIT_RST, BRAKE_RST, STOP_RST, 16'd3);
                4: apply_cfg(16'd100, 16'd46341, 16'd0, 16'd5);
                default: apply_cfg(16'($urandom_range(0, 46341)),
                                   16'($urandom_range(0, 8000)),
                                   16'($urandom_range(0, 2000)),
                                   16'($urandom_range(0, 12)));
            endcase
            if (p == 1) begin
                // zero limit and zero hold
                directed_cmds.push_back(mk_cmd(1, 0, 5, 0));
                directed_cmds.push_back(mk_cmd(-1, -1, -3, 0));
                directed_cmds.push_back(mk_cmd(20000, 0, 6, 0));
                directed_cmds.push_back(mk_cmd(0, 0, 4, 0));
                play_directed();
                drain();
            end
            if (p == 3) long_stall_req = 1'b1;
            sent = 0;
            while (sent < PER_PHASE) begin
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
                for (int k = 0; k < burst && sent < PER_PHASE; k++) begin
                    send_cmd(next_cmd());
                    sent++;
                end
                s_valid <= 1'b0;
                gap = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 70)
                                                  : $urandom_range(1, 12);
                repeat (gap) @(posedge aclk);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
